// File: hw/rtl/rrf_pkg.sv
// Shared types, codes and helper functions of the Ridders root finder.
package rrf_pkg;

  // Search limits.
  localparam logic [9:0] MAX_ITERATIONS = 10'd64;

  // Input operations.
  localparam logic OP_START = 1'b0;
  localparam logic OP_VALUE = 1'b1;

  // Result kinds.
  localparam logic KIND_EVAL   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_CHANGE  = 3'd1;
  localparam logic [2:0] ST_NO_EST     = 3'd2;
  localparam logic [2:0] ST_ITER_LIMIT = 3'd3;
  localparam logic [2:0] ST_BAD_SIGNS  = 3'd4;
  localparam logic [2:0] ST_UNEXPECTED = 3'd5;

  // Search phases: which function value the block waits for.
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_FL   = 3'd1;
  localparam logic [2:0] PH_FH   = 3'd2;
  localparam logic [2:0] PH_FM   = 3'd3;
  localparam logic [2:0] PH_FN   = 3'd4;

  // Serial unit operations.
  localparam logic [1:0] SU_MUL  = 2'd0;
  localparam logic [1:0] SU_SQRT = 2'd1;
  localparam logic [1:0] SU_DIV  = 2'd2;

  // Command to the serial unit.
  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } su_cmd_t;

  // Status from the serial unit.
  typedef struct packed {
    logic busy;
    logic done;
  } su_stat_t;

  // Magnitude of a signed 32-bit value, exact for the most negative value.
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Floor of the average of two signed values.
  function automatic logic signed [31:0] midpoint(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    midpoint = s[32:1];
  endfunction

  // True when a is nonzero and its sign differs from that of b.
  function automatic logic differs(input logic signed [31:0] a,
                                   input logic signed [31:0] b);
    differs = (a != 32'sd0) && (a[31] != b[31]);
  endfunction

endpackage

// File: hw/rtl/rrf_in_if.sv
// Request channel into the root finder: operation, bracket and function value.
interface rrf_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] lower_bound;
  logic signed [31:0] upper_bound;
  logic signed [31:0] f_value;

  modport source (output valid, operation, lower_bound, upper_bound, f_value,
                  input ready);
  modport sink (input valid, operation, lower_bound, upper_bound, f_value,
                output ready);
endinterface

// File: hw/rtl/rrf_out_if.sv
// Request channel out of the root finder: evaluation point or final root.
interface rrf_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] x_point;
  logic [2:0]         status;

  modport source (output valid, kind, x_point, status, input ready);
  modport sink (input valid, kind, x_point, status, output ready);
endinterface

// File: hw/rtl/rrf_serial_unit.sv
// Bit-serial multiply, square root and divide unit shared by the search steps.
module rrf_serial_unit (
  input  logic              clk,
  input  logic              rst,
  input  rrf_pkg::su_cmd_t  cmd,
  input  logic [63:0]       opa,
  input  logic [31:0]       opb,
  output rrf_pkg::su_stat_t stat,
  output logic [63:0]       result
);

  logic [1:0]  op;
  logic        busy;
  logic        done;
  logic [6:0]  cnt;
  logic [33:0] hi;
  logic [63:0] lo;
  logic [31:0] root;
  logic [31:0] divisor;

  logic [33:0] hi_next;
  logic [63:0] lo_next;
  logic [31:0] root_next;

  logic [32:0] msum;
  logic [33:0] srem;
  logic [33:0] strial;
  logic        sge;
  logic [32:0] drem;
  logic        dge;

  // One step of the selected operation.
  always_comb begin
    msum   = {1'b0, hi[31:0]} + (lo[0] ? {1'b0, divisor} : 33'd0);
    srem   = {hi[31:0], lo[63:62]};
    strial = {root, 2'b01};
    sge    = (srem >= strial);
    drem   = {hi[31:0], lo[63]};
    dge    = (drem >= {1'b0, divisor});
    hi_next   = hi;
    lo_next   = lo;
    root_next = root;
    unique case (op)
      rrf_pkg::SU_MUL: begin
        hi_next = {2'b00, msum[32:1]};
        lo_next = {32'd0, msum[0], lo[31:1]};
      end
      rrf_pkg::SU_SQRT: begin
        hi_next   = sge ? (srem - strial) : srem;
        root_next = {root[30:0], sge};
        lo_next   = {lo[61:0], 2'b00};
      end
      rrf_pkg::SU_DIV: begin
        hi_next = {1'b0, dge ? (drem - {1'b0, divisor}) : drem};
        lo_next = {lo[62:0], dge};
      end
      default: begin
        hi_next = hi;
      end
    endcase
  end

  // Sequencing: load on start, step while busy, pulse done after the last step.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= (cmd.op == rrf_pkg::SU_DIV) ? 7'd63 : 7'd31;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and working registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op      <= cmd.op;
      hi      <= 34'd0;
      lo      <= opa;
      root    <= 32'd0;
      divisor <= opb;
    end else if (busy) begin
      hi   <= hi_next;
      lo   <= lo_next;
      root <= root_next;
    end
  end

  // Result selection.
  always_comb begin
    unique case (op)
      rrf_pkg::SU_MUL:  result = {hi[31:0], lo[31:0]};
      rrf_pkg::SU_SQRT: result = {32'd0, root};
      default:          result = lo;
    endcase
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: hw/rtl/ridders_root_finder_unit.sv
// Top level of the Ridders root finder: search sequencer and output register.
//
//  Channel         Dir  Payload
//  req_in          in   operation, lower_bound, upper_bound, f_value
//  req_out         out  kind, x_point, status
//  cfg_write_*     in   tolerance (31 bits)
//
// A start, a left or right endpoint value, or an unexpected value goes straight to the
// emit step. A value at the estimate passes the width test first unless it ends the
// search. A midpoint value runs two multiplies, a square root, a multiply and a divide,
// all in the one bit-serial unit. A request is taken only when the sequencer is idle;
// a waiting result holds only the final emit step.
// Reset is synchronous and returns the search to idle with tolerance 1.
module ridders_root_finder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [30:0] cfg_write_data,
  rrf_in_if.sink      req_in,
  rrf_out_if.source   req_out
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EMIT  = 4'd1;
  localparam logic [3:0] S_WIDTH = 4'd2;
  localparam logic [3:0] S_MULP  = 4'd3;
  localparam logic [3:0] S_MULQ  = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_MULN  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;

  logic [3:0]         ctl;
  logic [2:0]         phase;
  logic [9:0]         iteration;
  logic [30:0]        tolerance;
  logic signed [31:0] x_left, x_right, f_left, f_right, x_mid, f_mid, estimate;
  logic               estimate_valid;
  logic signed [31:0] x_new;
  logic [63:0]        p_sq;
  logic [31:0]        s_root;
  logic               num_neg;

  logic               res_kind;
  logic signed [31:0] res_x;
  logic [2:0]         res_status;

  logic               out_valid;
  logic               out_kind;
  logic signed [31:0] out_x;
  logic [2:0]         out_status;
  logic               out_load;

  rrf_pkg::su_cmd_t   su_cmd;
  rrf_pkg::su_stat_t  su_stat;
  logic [63:0]        su_a;
  logic [31:0]        su_b;
  logic [63:0]        su_result;

  logic               accept;
  logic signed [31:0] fv;
  logic               q_pos;
  logic [63:0]        rad_sum;
  logic signed [32:0] diff_xm;
  logic [32:0]        diff_mag;
  logic signed [65:0] est_sum;
  logic signed [32:0] est_delta;
  logic [32:0]        est_delta_mag;
  logic signed [32:0] width;
  logic [32:0]        width_mag;
  logic [9:0]         iteration_next;

  rrf_serial_unit u_serial (
    .clk    (clk),
    .rst    (rst),
    .cmd    (su_cmd),
    .opa    (su_a),
    .opb    (su_b),
    .stat   (su_stat),
    .result (su_result)
  );

  // Handshake on both channels.
  assign req_in.ready      = (ctl == S_IDLE);
  assign accept            = req_in.valid && req_in.ready;
  assign fv                = req_in.f_value;
  assign out_load          = (ctl == S_EMIT) && (!out_valid || req_out.ready);
  assign req_out.valid     = out_valid;
  assign req_out.kind      = out_kind;
  assign req_out.x_point   = out_x;
  assign req_out.status    = out_status;

  // Arithmetic around the serial unit.
  always_comb begin
    q_pos         = (f_left != 32'sd0) && (f_right != 32'sd0) && (f_left[31] == f_right[31]);
    rad_sum       = p_sq + su_result;
    diff_xm       = {x_mid[31], x_mid} - {x_left[31], x_left};
    diff_mag      = diff_xm[32] ? 33'(-diff_xm) : 33'(diff_xm);
    est_sum       = 66'(x_mid) + (num_neg ? -$signed({2'b00, su_result})
                                          : $signed({2'b00, su_result}));
    est_delta     = {x_new[31], x_new} - {estimate[31], estimate};
    est_delta_mag = est_delta[32] ? 33'(-est_delta) : 33'(est_delta);
    width         = {x_right[31], x_right} - {x_left[31], x_left};
    width_mag     = width[32] ? 33'(-width) : 33'(width);
    iteration_next = iteration + 10'd1;
  end

  // Tolerance register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= 31'd1;
    end else if (cfg_write_en) begin
      tolerance <= cfg_write_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (req_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind   <= res_kind;
      out_x      <= res_x;
      out_status <= res_status;
    end
  end

  // Search sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl            <= S_IDLE;
      phase          <= rrf_pkg::PH_IDLE;
      iteration      <= 10'd0;
      estimate_valid <= 1'b0;
      su_cmd         <= '0;
      x_left         <= 32'sd0;
      x_right        <= 32'sd0;
      f_left         <= 32'sd0;
      f_right        <= 32'sd0;
      x_mid          <= 32'sd0;
      f_mid          <= 32'sd0;
      estimate       <= 32'sd0;
    end else begin
      su_cmd.start <= 1'b0;
      unique case (ctl)
        S_IDLE: begin
          if (accept) begin
            ctl        <= S_EMIT;
            res_kind   <= rrf_pkg::KIND_EVAL;
            res_status <= rrf_pkg::ST_OK;
            if (req_in.operation == rrf_pkg::OP_START) begin
              x_left         <= req_in.lower_bound;
              x_right        <= req_in.upper_bound;
              estimate_valid <= 1'b0;
              iteration      <= 10'd0;
              phase          <= rrf_pkg::PH_FL;
              res_x          <= req_in.lower_bound;
            end else begin
              unique case (phase)
                rrf_pkg::PH_FL: begin
                  f_left <= fv;
                  phase  <= rrf_pkg::PH_FH;
                  res_x  <= x_right;
                end
                rrf_pkg::PH_FH: begin
                  f_right <= fv;
                  if ((f_left == 32'sd0) || (fv == 32'sd0) || (f_left[31] == fv[31])) begin
                    phase    <= rrf_pkg::PH_IDLE;
                    res_kind <= rrf_pkg::KIND_FINISH;
                    if (f_left == 32'sd0) begin
                      res_x <= x_left;
                    end else if (fv == 32'sd0) begin
                      res_x <= x_right;
                    end else begin
                      res_x      <= 32'sd0;
                      res_status <= rrf_pkg::ST_NO_CHANGE;
                    end
                  end else begin
                    estimate_valid <= 1'b0;
                    iteration      <= 10'd1;
                    x_mid          <= rrf_pkg::midpoint(x_left, x_right);
                    res_x          <= rrf_pkg::midpoint(x_left, x_right);
                    phase          <= rrf_pkg::PH_FM;
                  end
                end
                rrf_pkg::PH_FM: begin
                  // Square of the midpoint value first.
                  f_mid        <= fv;
                  ctl          <= S_MULP;
                  su_cmd.start <= 1'b1;
                  su_cmd.op    <= rrf_pkg::SU_MUL;
                  su_a         <= {32'd0, rrf_pkg::mag32(fv)};
                  su_b         <= rrf_pkg::mag32(fv);
                end
                rrf_pkg::PH_FN: begin
                  if (fv == 32'sd0) begin
                    phase    <= rrf_pkg::PH_IDLE;
                    res_kind <= rrf_pkg::KIND_FINISH;
                    res_x    <= estimate;
                  end else if (rrf_pkg::differs(f_mid, fv)) begin
                    x_left  <= x_mid;
                    f_left  <= f_mid;
                    x_right <= estimate;
                    f_right <= fv;
                    ctl     <= S_WIDTH;
                  end else if (rrf_pkg::differs(f_left, fv)) begin
                    x_right <= estimate;
                    f_right <= fv;
                    ctl     <= S_WIDTH;
                  end else if (rrf_pkg::differs(f_right, fv)) begin
                    x_left <= estimate;
                    f_left <= fv;
                    ctl    <= S_WIDTH;
                  end else begin
                    phase      <= rrf_pkg::PH_IDLE;
                    res_kind   <= rrf_pkg::KIND_FINISH;
                    res_x      <= 32'sd0;
                    res_status <= rrf_pkg::ST_BAD_SIGNS;
                  end
                end
                default: begin
                  phase      <= rrf_pkg::PH_IDLE;
                  res_kind   <= rrf_pkg::KIND_FINISH;
                  res_x      <= 32'sd0;
                  res_status <= rrf_pkg::ST_UNEXPECTED;
                end
              endcase
            end
          end
        end
        S_EMIT: begin
          if (out_load) begin
            ctl <= S_IDLE;
          end
        end
        S_WIDTH: begin
          // Bracket width test, iteration count and next midpoint.
          ctl        <= S_EMIT;
          res_status <= rrf_pkg::ST_OK;
          if (width_mag <= {2'b00, tolerance}) begin
            phase    <= rrf_pkg::PH_IDLE;
            res_kind <= rrf_pkg::KIND_FINISH;
            res_x    <= estimate;
          end else begin
            iteration <= iteration_next;
            if (iteration_next >= rrf_pkg::MAX_ITERATIONS) begin
              phase      <= rrf_pkg::PH_IDLE;
              res_kind   <= rrf_pkg::KIND_FINISH;
              res_x      <= 32'sd0;
              res_status <= rrf_pkg::ST_ITER_LIMIT;
            end else begin
              x_mid    <= rrf_pkg::midpoint(x_left, x_right);
              res_x    <= rrf_pkg::midpoint(x_left, x_right);
              res_kind <= rrf_pkg::KIND_EVAL;
              phase    <= rrf_pkg::PH_FM;
            end
          end
        end
        S_MULP: begin
          if (su_stat.done) begin
            p_sq         <= su_result;
            ctl          <= S_MULQ;
            su_cmd.start <= 1'b1;
            su_cmd.op    <= rrf_pkg::SU_MUL;
            su_a         <= {32'd0, rrf_pkg::mag32(f_left)};
            su_b         <= rrf_pkg::mag32(f_right);
          end
        end
        S_MULQ: begin
          // Radicand fm*fm - fl*fh; a negative one falls back to the midpoint.
          if (su_stat.done) begin
            if (!q_pos) begin
              ctl          <= S_SQRT;
              su_cmd.start <= 1'b1;
              su_cmd.op    <= rrf_pkg::SU_SQRT;
              su_a         <= rad_sum;
            end else if (p_sq >= su_result) begin
              ctl          <= S_SQRT;
              su_cmd.start <= 1'b1;
              su_cmd.op    <= rrf_pkg::SU_SQRT;
              su_a         <= p_sq - su_result;
            end else begin
              x_new <= x_mid;
              ctl   <= S_CMP;
            end
          end
        end
        S_SQRT: begin
          if (su_stat.done) begin
            s_root <= su_result[31:0];
            if (su_result[31:0] == 32'd0) begin
              ctl        <= S_EMIT;
              phase      <= rrf_pkg::PH_IDLE;
              res_kind   <= rrf_pkg::KIND_FINISH;
              res_x      <= estimate_valid ? estimate : 32'sd0;
              res_status <= estimate_valid ? rrf_pkg::ST_OK : rrf_pkg::ST_NO_EST;
            end else begin
              num_neg      <= diff_xm[32] ^ f_mid[31] ^ (f_left < f_right);
              ctl          <= S_MULN;
              su_cmd.start <= 1'b1;
              su_cmd.op    <= rrf_pkg::SU_MUL;
              su_a         <= {32'd0, diff_mag[31:0]};
              su_b         <= rrf_pkg::mag32(f_mid);
            end
          end
        end
        S_MULN: begin
          if (su_stat.done) begin
            ctl          <= S_DIV;
            su_cmd.start <= 1'b1;
            su_cmd.op    <= rrf_pkg::SU_DIV;
            su_a         <= su_result;
            su_b         <= s_root;
          end
        end
        S_DIV: begin
          // New estimate, saturated to the 32-bit range.
          if (su_stat.done) begin
            ctl <= S_CMP;
            if (est_sum > 66'sd2147483647) begin
              x_new <= 32'sh7FFFFFFF;
            end else if (est_sum < -66'sd2147483648) begin
              x_new <= 32'sh80000000;
            end else begin
              x_new <= est_sum[31:0];
            end
          end
        end
        S_CMP: begin
          // Convergence on the change of the estimate.
          ctl        <= S_EMIT;
          res_status <= rrf_pkg::ST_OK;
          if (estimate_valid && (est_delta_mag <= {2'b00, tolerance})) begin
            phase    <= rrf_pkg::PH_IDLE;
            res_kind <= rrf_pkg::KIND_FINISH;
            res_x    <= estimate;
          end else begin
            estimate       <= x_new;
            estimate_valid <= 1'b1;
            phase          <= rrf_pkg::PH_FN;
            res_kind       <= rrf_pkg::KIND_EVAL;
            res_x          <= x_new;
          end
        end
        default: begin
          ctl <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // A new request is never taken while the serial unit is still working.
  a_idle_unit_free: assert property (@(posedge clk) disable iff (rst)
    req_in.ready |-> !su_stat.busy)
    else $error("request taken while serial unit busy");

  // A finished result always leaves the search idle.
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && (res_kind == rrf_pkg::KIND_FINISH)) |-> (phase == rrf_pkg::PH_IDLE))
    else $error("finished result while search still active");

  // Waiting for the value at the estimate implies an estimate exists.
  a_fn_has_estimate: assert property (@(posedge clk) disable iff (rst)
    (phase == rrf_pkg::PH_FN) |-> estimate_valid)
    else $error("estimate phase without a valid estimate");
`endif

endmodule
